// File: src/hcbd_pkg.sv
// shared types and constants for the huffman codebook bit decoder
package hcbd_pkg;

    localparam int MAX_ENTRIES_DEF   = 256;
    localparam int MAX_CODE_BITS_DEF = 32;

    localparam int CODE_W        = 32;
    localparam int LEN_W         = 6;
    localparam int ENTRY_INDEX_W = 8;
    localparam int SYMBOL_W      = 8;
    localparam int CFG_W         = 9;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_DECODE = 1'b1
    } command_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_we;
        logic take_bit;
        logic issue;
        logic hold_cmp;
        logic emit_hit;
        logic emit_err;
        logic clear_code;
    } hcbd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic scan_end;
        logic count_full;
        logic out_free;
    } hcbd_stat_t;

endpackage

// File: src/huffman_codebook_bit_decoder_top.sv
// top level of the bit-serial huffman codebook decoder
// Bit-serial Huffman codebook decoder. A word with command load writes one
// codeword and its length into the table slot entry_index (modulo
// MAX_ENTRIES) while the block stays idle. A word with command decode shifts
// stream_bit into the code accumulator, msb first, and then scans the table
// entries 0 .. entries_in_use-1 (capped at MAX_ENTRIES) through the single
// table read port, one entry per cycle. The first entry whose code and
// length equal the accumulated bits gives a result word with its index in
// symbol; once MAX_CODE_BITS bits pass with no match a result word with
// no_match set and symbol zero is given. Either result clears the
// accumulator. A decode word therefore occupies the block until the table
// scan ends or a match stops it early, and a hit or error result can also
// wait for the output register to free; a load word does not. The
// result sits in an output register, so a new word is accepted while a
// result still waits behind out_stall. The table is not cleared at reset:
// search only entries that were loaded. entries_in_use may be written only
// while the block is idle.
module huffman_codebook_bit_decoder_top
    import hcbd_pkg::*;
#(
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         entries_in_use,

    // input word channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [ENTRY_INDEX_W-1:0] entry_index,
    input  logic [CODE_W-1:0]        entry_code,
    input  logic [LEN_W-1:0]         entry_length,
    input  logic                     stream_bit,

    // result word channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [SYMBOL_W-1:0]      symbol,
    output logic                     no_match
);

    hcbd_cmd_t  cmd;
    hcbd_stat_t stat;

    // the user must issue register writes only while idle; the block does not enforce it and is always ready
    assign cfg_ready = 1'b1;

    // sequencing: accept, scan, emit
    hcbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, accumulator, scan pointer and result register
    hcbd_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .entry_index  (entry_index),
        .entry_code   (entry_code),
        .entry_length (entry_length),
        .stream_bit   (stream_bit),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (entries_in_use),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol       (symbol),
        .no_match     (no_match)
    );

endmodule

// File: src/hcbd_ctrl.sv
// control state machine for the huffman codebook bit decoder
module hcbd_ctrl
    import hcbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  hcbd_stat_t stat,
    output hcbd_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (command == CMD_DECODE))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.hit)
                begin
                    if (stat.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (stat.scan_end)
                begin
                    if (!stat.count_full || stat.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_we  = in_valid && (command == CMD_LOAD);
                cmd.take_bit = in_valid && (command == CMD_DECODE);
            end
            ST_SCAN:
            begin
                if (stat.hit)
                begin
                    // keep the matching compare until the output can take it
                    cmd.hold_cmp   = !stat.out_free;
                    cmd.emit_hit   = stat.out_free;
                    cmd.clear_code = stat.out_free;
                end
                else if (stat.scan_end)
                begin
                    cmd.emit_err   = stat.count_full && stat.out_free;
                    cmd.clear_code = stat.count_full && stat.out_free;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: src/hcbd_datapath.sv
// table memory, code accumulator, scan pointer and output register
module hcbd_datapath
    import hcbd_pkg::*;
#(
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hcbd_cmd_t                cmd,
    output hcbd_stat_t               stat,
    input  logic [ENTRY_INDEX_W-1:0] entry_index,
    input  logic [CODE_W-1:0]        entry_code,
    input  logic [LEN_W-1:0]         entry_length,
    input  logic                     stream_bit,
    input  logic                     cfg_we,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [SYMBOL_W-1:0]      symbol,
    output logic                     no_match
);

    localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SCAN_W     = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W      = $clog2(MAX_CODE_BITS + 1);
    localparam int SLOT_COUNT = 2 ** ENTRY_INDEX_W;
    localparam int WORD_W     = CODE_W + LEN_W;

    // slot of each possible entry index, modulo the table depth
    logic [IDX_W-1:0] slot_lut [SLOT_COUNT];

    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_slot
        assign slot_lut[g] = IDX_W'(g % MAX_ENTRIES);
    end

    logic [WORD_W-1:0] mem [MAX_ENTRIES];
    logic [WORD_W-1:0] rd_word_reg;

    logic [MAX_CODE_BITS-1:0] acc_reg;
    logic [MAX_CODE_BITS-1:0] acc_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [SCAN_W-1:0]        limit_reg;
    logic [SCAN_W-1:0]        limit_next;
    logic [SCAN_W-1:0]        rd_idx_reg;
    logic [SCAN_W-1:0]        rd_idx_next;
    logic                     cmp_valid_reg;
    logic                     cmp_valid_next;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [SYMBOL_W-1:0]      symbol_reg;
    logic                     no_match_reg;

    logic [31:0]       cmp_idx_wide;
    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;

    // table write and registered scan read
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            mem[slot_lut[entry_index]] <= {entry_code, entry_length};
        end
        if (cmd.issue)
        begin
            rd_word_reg <= mem[rd_idx_reg[IDX_W-1:0]];
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
    end

    assign rd_code = rd_word_reg[WORD_W-1:LEN_W];
    assign rd_len  = rd_word_reg[LEN_W-1:0];

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_we)
        begin
            if (32'(cfg_data) > 32'(MAX_ENTRIES))
            begin
                limit_next = SCAN_W'(MAX_ENTRIES);
            end
            else
            begin
                limit_next = SCAN_W'(cfg_data);
            end
        end

        acc_next   = acc_reg;
        count_next = count_reg;
        if (cmd.take_bit)
        begin
            acc_next   = MAX_CODE_BITS'({acc_reg, stream_bit});
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.clear_code)
        begin
            acc_next   = '0;
            count_next = '0;
        end

        rd_idx_next = rd_idx_reg;
        if (cmd.take_bit)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.issue)
        begin
            rd_idx_next = rd_idx_reg + SCAN_W'(1);
        end

        if (cmd.issue)
        begin
            cmp_valid_next = 1'b1;
        end
        else if (cmd.hold_cmp)
        begin
            cmp_valid_next = cmp_valid_reg;
        end
        else
        begin
            cmp_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit_hit || cmd.emit_err)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            count_reg     <= '0;
            limit_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmp_idx_wide = 32'(cmp_idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit_hit)
        begin
            symbol_reg   <= cmp_idx_wide[SYMBOL_W-1:0];
            no_match_reg <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            symbol_reg   <= '0;
            no_match_reg <= 1'b1;
        end
    end

    assign stat.hit        = cmp_valid_reg
                             && (rd_code == CODE_W'(acc_reg))
                             && (rd_len == LEN_W'(count_reg));
    assign stat.scan_end   = (rd_idx_reg >= limit_reg);
    assign stat.count_full = (32'(count_reg) >= 32'(MAX_CODE_BITS));
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign no_match  = no_match_reg;

endmodule

// File: bench/tb_huffman_codebook_bit_decoder_top.sv
// self-checking testbench for the bit-serial huffman codebook decoder
`timescale 1ns / 100ps

module tb_huffman_codebook_bit_decoder_top;

    import hcbd_pkg::*;

    // a decode word scans at most MAX_ENTRIES entries,
    // so this many quiet cycles always covers a scan that ends without a result word
    localparam int DRAIN_CYCLES = 300;
    // slowest legal run is about 1900 words at a full 256-entry scan with heavy
    // receiver stall; the limit sits several times above that
    localparam int CYCLE_LIMIT  = 3000000;

    // phase markers for a randomly chosen table size
    localparam int PICK_SMALL = -1;
    localparam int PICK_WIDE  = -2;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef enum int {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                no_match;
    } result_t;

    // one row of the directed table; reps repeats the same word, and a typed
    // expectation applies to the last repeat only
    typedef struct packed {
        row_kind_t                kind;
        command_t                 cmd;
        logic [ENTRY_INDEX_W-1:0] idx;
        logic [CODE_W-1:0]        code;
        logic [LEN_W-1:0]         len;
        logic                     bitv;
        int                       reps;
        logic                     typed;
        logic [SYMBOL_W-1:0]      exp_symbol;
        logic                     exp_no_match;
        logic [CFG_W-1:0]         cfg_value;
    } stim_row_t;

    typedef struct packed {
        int         count;
        int         words;
        idle_mode_t mode;
    } phase_t;

    localparam stim_row_t DIRECTED [0:16] = '{
        // empty table right after reset: nothing is searched, 32 bits give an error word
        '{ROW_WORD, CMD_DECODE, 8'd0,   32'h0,        6'd0,  1'b1, 31, 1'b0, 8'd0, 1'b0, 9'd0},
        '{ROW_WORD, CMD_DECODE, 8'd0,   32'h0,        6'd0,  1'b0, 1,  1'b1, 8'd0, 1'b1, 9'd0},
        // small prefix code "0", "10", "110"
        '{ROW_WORD, CMD_LOAD,   8'd0,   32'h0,        6'd1,  1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        '{ROW_WORD, CMD_LOAD,   8'd1,   32'h2,        6'd2,  1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        '{ROW_WORD, CMD_LOAD,   8'd2,   32'h6,        6'd3,  1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        // duplicate of slot 2, must lose to the lower index
        '{ROW_WORD, CMD_LOAD,   8'd3,   32'h6,        6'd3,  1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        // full-width all-ones codeword
        '{ROW_WORD, CMD_LOAD,   8'd4,   32'hFFFFFFFF, 6'd32, 1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        // zero length, never matches
        '{ROW_WORD, CMD_LOAD,   8'd5,   32'h7,        6'd0,  1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        // length beyond the longest code, never matches
        '{ROW_WORD, CMD_LOAD,   8'd6,   32'h1F,       6'd63, 1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        // code has bits above its length, never matches
        '{ROW_WORD, CMD_LOAD,   8'd7,   32'h1F,       6'd3,  1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        // top slot
        '{ROW_WORD, CMD_LOAD,   8'd255, 32'hA5A5A5A5, 6'd32, 1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        '{ROW_CFG,  CMD_LOAD,   8'd0,   32'h0,        6'd0,  1'b0, 1,  1'b0, 8'd0, 1'b0, 9'd8},
        // "0" -> 0, "10" -> 1, "110" -> 2
        '{ROW_WORD, CMD_DECODE, 8'd0,   32'h0,        6'd0,  1'b0, 1,  1'b1, 8'd0, 1'b0, 9'd0},
        '{ROW_WORD, CMD_DECODE, 8'd0,   32'h0,        6'd0,  1'b1, 1,  1'b0, 8'd0, 1'b0, 9'd0},
        '{ROW_WORD, CMD_DECODE, 8'd0,   32'h0,        6'd0,  1'b0, 1,  1'b1, 8'd1, 1'b0, 9'd0},
        '{ROW_WORD, CMD_DECODE, 8'd0,   32'h0,        6'd0,  1'b1, 2,  1'b0, 8'd0, 1'b0, 9'd0},
        '{ROW_WORD, CMD_DECODE, 8'd0,   32'h0,        6'd0,  1'b0, 1,  1'b1, 8'd2, 1'b0, 9'd0}
    };

    // random part: table size, word count and idling style of each phase;
    // most phases keep the table small so the serial scan stays short
    localparam phase_t PHASES [0:10] = '{
        '{256,        60,  IDLE_RX_HEAVY},
        '{1,          150, IDLE_RX_HEAVY},
        '{5,          200, IDLE_RX_HEAVY},
        '{PICK_SMALL, 200, IDLE_TX_HEAVY},
        '{511,        40,  IDLE_TX_HEAVY},
        '{12,         200, IDLE_TX_HEAVY},
        '{PICK_SMALL, 250, IDLE_NONE},
        '{0,          40,  IDLE_NONE},
        '{3,          200, IDLE_NONE},
        '{PICK_WIDE,  60,  IDLE_NONE},
        '{7,          150, IDLE_NONE}
    };

    // clock, reset and the block's ports, all known from time zero
    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         entries_in_use = '0;
    logic                     in_valid       = 1'b0;
    logic                     in_stall;
    logic                     command        = CMD_LOAD;
    logic [ENTRY_INDEX_W-1:0] entry_index    = '0;
    logic [CODE_W-1:0]        entry_code     = '0;
    logic [LEN_W-1:0]         entry_length   = '0;
    logic                     stream_bit     = 1'b0;
    logic                     out_valid;
    logic                     out_stall      = 1'b0;
    logic [SYMBOL_W-1:0]      symbol;
    logic                     no_match;

    // predictor state: the codebook, the bit accumulator and the table size
    logic [CODE_W-1:0] model_code [MAX_ENTRIES_DEF];
    logic [LEN_W-1:0]  model_len  [MAX_ENTRIES_DEF];
    logic [CODE_W-1:0] model_acc         = '0;
    logic [LEN_W-1:0]  model_bits        = '0;
    logic [CFG_W-1:0]  model_entry_count = '0;

    // decoded words still owed by the block, oldest first
    result_t pending_symbols [$];
    result_t oldest;

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int fails        = 0;
    int cycle_count  = 0;

    huffman_codebook_bit_decoder_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .entries_in_use (entries_in_use),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .entry_index    (entry_index),
        .entry_code     (entry_code),
        .entry_length   (entry_length),
        .stream_bit     (stream_bit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .symbol         (symbol),
        .no_match       (no_match)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_huffman_codebook_bit_decoder_top NOT OK");
            $finish;
        end
    end

    // result side: take a word whenever valid and not stalled, compare it with
    // the oldest expectation, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_symbols.size() == 0)
            begin
                $error("unexpected result word: symbol %0d no_match %0d", symbol, no_match);
                fails++;
            end
            else
            begin
                oldest = pending_symbols.pop_front();
                if (symbol !== oldest.symbol)
                begin
                    $error("symbol: expected %0d, got %0d", oldest.symbol, symbol);
                    fails++;
                end
                if (no_match !== oldest.no_match)
                begin
                    $error("no_match: expected %0d, got %0d", oldest.no_match, no_match);
                    fails++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // one accepted word through the codebook: a load writes a slot, a decode shifts
    // in a bit and searches the table in index order; 32 bits with no hit is an error
    task automatic huffman_lookup(input command_t cmd, input logic [ENTRY_INDEX_W-1:0] idx,
                                  input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                  input logic b, output bit got, output result_t res);
        int lim;
        got = 1'b0;
        res = '0;
        if (cmd == CMD_LOAD)
        begin
            model_code[idx] = code;
            model_len[idx]  = len;
        end
        else
        begin
            model_acc  = {model_acc[CODE_W-2:0], b};
            model_bits = model_bits + LEN_W'(1);
            lim = (model_entry_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF
                                                         : int'(model_entry_count);
            for (int i = 0; i < lim && !got; i++)
            begin
                if (model_code[i] == model_acc && model_len[i] == model_bits)
                begin
                    got        = 1'b1;
                    res.symbol = i[SYMBOL_W-1:0];
                end
            end
            if (!got && model_bits >= MAX_CODE_BITS_DEF)
            begin
                got          = 1'b1;
                res.no_match = 1'b1;
            end
            if (got)
            begin
                model_acc  = '0;
                model_bits = '0;
            end
        end
    endtask

    // drive one word, hold it until accepted, then predict; a typed expectation
    // takes the place of the predicted one
    task automatic apply_word(input command_t cmd, input logic [ENTRY_INDEX_W-1:0] idx,
                              input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                              input logic b, input bit typed, input result_t typed_res,
                              output bit got);
        result_t res;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        entry_index  <= idx;
        entry_code   <= code;
        entry_length <= len;
        stream_bit   <= b;
        do @(posedge clk); while (in_stall);
        huffman_lookup(cmd, idx, code, len, b, got, res);
        if (typed)
            pending_symbols.push_back(typed_res);
        else if (got)
            pending_symbols.push_back(res);
    endtask

    // decode word with don't-care load fields
    task automatic feed_bit(input logic b, output bit got);
        logic [31:0] junk_a;
        logic [31:0] junk_b;
        junk_a = $urandom;
        junk_b = $urandom;
        apply_word(CMD_DECODE, junk_a[7:0], junk_b, junk_a[13:8], b, 1'b0, '0, got);
    endtask

    // mostly well-formed codewords, some with a stray high bit, zero or oversized length
    task automatic make_entry(output logic [CODE_W-1:0] code, output logic [LEN_W-1:0] len);
        int r;
        r    = $urandom_range(99);
        code = $urandom;
        if (r < 4)
            len = '0;
        else if (r < 8)
            len = LEN_W'($urandom_range(63, 33));
        else if (r < 14)
        begin
            len  = LEN_W'($urandom_range(31, 1));
            code = code | (32'h1 << len);
        end
        else
        begin
            len = (r < 24) ? LEN_W'($urandom_range(32, 20)) : LEN_W'($urandom_range(10, 1));
            if (len < 32)
                code = code & ((32'h1 << len) - 1);
        end
    endtask

    // stop sending and let every owed result word come back
    task automatic wait_drained;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_symbols.size() != 0);
    endtask

    // register write, only once the block is quiet
    task automatic set_entries_in_use(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid      <= 1'b1;
        entries_in_use <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid         <= 1'b0;
        model_entry_count = value;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_RX_HEAVY: begin in_idle_pct = 12; out_idle_pct = 82; end
            IDLE_TX_HEAVY: begin in_idle_pct = 82; out_idle_pct = 12; end
            default:       begin in_idle_pct = 0;  out_idle_pct = 0;  end
        endcase
    endtask

    initial
    begin
        stim_row_t         row;
        phase_t            ph;
        bit                got;
        bit                flip;
        int                value;
        int                lim;
        int                sent;
        int                pick;
        int                slot;
        int                n;
        int                stop;
        int                runlen;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              bitv;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        set_idle(IDLE_RX_HEAVY);
        for (int r = 0; r < $size(DIRECTED); r++)
        begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG)
                set_entries_in_use(row.cfg_value);
            else
                for (int k = 0; k < row.reps; k++)
                    apply_word(row.cmd, row.idx, row.code, row.len, row.bitv,
                               row.typed && (k == row.reps - 1),
                               '{row.exp_symbol, row.exp_no_match}, got);
        end

        // fill the whole table so any table size only ever searches loaded slots
        for (int s = 0; s < MAX_ENTRIES_DEF; s++)
        begin
            make_entry(code, len);
            apply_word(CMD_LOAD, s[ENTRY_INDEX_W-1:0], code, len, 1'($urandom_range(1, 0)),
                       1'b0, '0, got);
        end

        foreach (PHASES[p])
        begin
            ph = PHASES[p];
            set_idle(ph.mode);
            value = ph.count;
            if (value == PICK_SMALL)
                value = $urandom_range(40, 2);
            else if (value == PICK_WIDE)
                value = $urandom_range(255, 41);
            set_entries_in_use(value[CFG_W-1:0]);
            lim  = (value > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : value;
            sent = 0;
            while (sent < ph.words)
            begin
                pick = $urandom_range(99);
                slot = (lim > 0) ? $urandom_range(lim - 1) : 0;
                n    = int'(model_len[slot]);
                if (pick < 7)
                begin
                    // rewrite a random slot mid-stream
                    make_entry(code, len);
                    apply_word(CMD_LOAD, ENTRY_INDEX_W'($urandom_range(255)), code, len,
                               1'($urandom_range(1, 0)), 1'b0, '0, got);
                    sent++;
                end
                else if (pick < 82 && lim > 0 && n >= 1 && n <= MAX_CODE_BITS_DEF &&
                         (n == MAX_CODE_BITS_DEF || (model_code[slot] >> n) == 0))
                begin
                    // codeword of a searched slot, msb first; a broken one flips a bit
                    // part way; stop as soon as a result comes so the next one starts clean
                    stop = n;
                    flip = 1'b0;
                    if (pick >= 75 && n > 1)
                    begin
                        stop = $urandom_range(n - 1, 1);
                        flip = 1'b1;
                    end
                    got = 1'b0;
                    for (int k = 0; k < stop && !got; k++)
                    begin
                        bitv = model_code[slot][n - 1 - k];
                        if (flip && k == stop - 1)
                            bitv = ~bitv;
                        feed_bit(bitv, got);
                        sent++;
                    end
                end
                else
                begin
                    // noise bits
                    runlen = $urandom_range(12, 1);
                    for (int k = 0; k < runlen; k++)
                    begin
                        feed_bit(1'($urandom_range(1, 0)), got);
                        sent++;
                    end
                end
                // now and then hold off until the block has handed back everything
                if ($urandom_range(299) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("tb_huffman_codebook_bit_decoder_top OK");
        else
            $display("tb_huffman_codebook_bit_decoder_top NOT OK");
        $finish;
    end

endmodule
